// ===== hdl/papc_pkg.sv =====
// Package for the persistent array path-copy block: sizes, codes and the shared node write type.
// No dependencies.
`timescale 1ns / 1ps
package papc_pkg;
  localparam int LeafCount    = 1024;
  localparam int VersionCount = 4096;
  localparam int NodeCount    = 65536;
  localparam int ValueBits    = 32;
  localparam int NodeBits     = 16;
  localparam int VerBits      = 12;
  localparam int PosBits      = 11;
  localparam int FreeBits     = 17;

  localparam logic [1:0] OpLoad   = 2'd0;
  localparam logic [1:0] OpModify = 2'd1;
  localparam logic [1:0] OpQuery  = 2'd2;

  localparam logic [2:0] StOk      = 3'd0;
  localparam logic [2:0] StBadVer  = 3'd1;
  localparam logic [2:0] StBadPos  = 3'd2;
  localparam logic [2:0] StFull    = 3'd3;
  localparam logic [2:0] StLate    = 3'd4;

  // One node write request toward the node memory.
  typedef struct packed {
    logic                  we;
    logic [NodeBits-1:0]   addr;
    logic                  wr_left;
    logic                  wr_right;
    logic                  wr_val;
    logic [NodeBits-1:0]   left;
    logic [NodeBits-1:0]   right;
    logic [ValueBits-1:0]  val;
  } node_wr_t;
endpackage

// ===== hdl/papc_node_mem.sv =====
// Node store: left, right and value arrays, one write and one read port each.
// Depends on papc_pkg.
`timescale 1ns / 1ps
module papc_node_mem (
  input  logic                          clk_i,
  input  papc_pkg::node_wr_t            wr_i,
  input  logic [papc_pkg::NodeBits-1:0] rd_addr_i,
  output logic [papc_pkg::NodeBits-1:0] rd_left_o,
  output logic [papc_pkg::NodeBits-1:0] rd_right_o,
  output logic [papc_pkg::ValueBits-1:0] rd_val_o
);
  logic [papc_pkg::NodeBits-1:0]  left_mem  [papc_pkg::NodeCount];
  logic [papc_pkg::NodeBits-1:0]  right_mem [papc_pkg::NodeCount];
  logic [papc_pkg::ValueBits-1:0] val_mem   [papc_pkg::NodeCount];

  always_ff @(posedge clk_i) begin
    if (wr_i.we && wr_i.wr_left) left_mem[wr_i.addr] <= wr_i.left;
    if (wr_i.we && wr_i.wr_right) right_mem[wr_i.addr] <= wr_i.right;
    if (wr_i.we && wr_i.wr_val) val_mem[wr_i.addr] <= wr_i.val;
    rd_left_o  <= left_mem[rd_addr_i];
    rd_right_o <= right_mem[rd_addr_i];
    rd_val_o   <= val_mem[rd_addr_i];
  end
endmodule

// ===== hdl/papc_root_mem.sv =====
// Version root table: one write port, one registered read port.
// Depends on papc_pkg.
`timescale 1ns / 1ps
module papc_root_mem (
  input  logic                          clk_i,
  input  logic                          we_i,
  input  logic [papc_pkg::VerBits-1:0]  wr_addr_i,
  input  logic [papc_pkg::NodeBits-1:0] wr_data_i,
  input  logic [papc_pkg::VerBits-1:0]  rd_addr_i,
  output logic [papc_pkg::NodeBits-1:0] rd_data_o
);
  logic [papc_pkg::NodeBits-1:0] mem [papc_pkg::VersionCount];

  always_ff @(posedge clk_i) begin
    if (we_i) mem[wr_addr_i] <= wr_data_i;
    rd_data_o <= mem[rd_addr_i];
  end
endmodule

// ===== hdl/persistent_array_path_copy.sv =====
// Top level of the persistent array: control sequencer over node and root memories.
// Depends on papc_pkg, papc_node_mem, papc_root_mem.
// A load walks down the tree in S_LOAD; a modify counts its depth, the leaf level (up to
// 10), in S_DEPTH and ends there when short of nodes; query and modify then pass S_ROOT,
// S_WAIT and S_WALK; flagged items go straight to S_DONE. The next may start at the result edge.
// The receiver cannot stall: done_o is high for one cycle with the result, busy_o low.
// Reset is asynchronous active low; version 0 root is node 1 without a memory pass.
`timescale 1ns / 1ps
module persistent_array_path_copy (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [10:0] cfg_wdata_i,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [1:0]  op_i,
  input  logic [11:0] version_i,
  input  logic [10:0] position_i,
  input  logic signed [31:0] value_i,
  output logic        done_o,
  output logic [2:0]  status_o,
  output logic signed [31:0] read_value_o,
  output logic [11:0] new_version_o
);
  localparam int NB = papc_pkg::NodeBits;
  localparam int VB = papc_pkg::VerBits;

  typedef enum logic [2:0] {
    S_IDLE, S_LOAD, S_DEPTH, S_ROOT, S_WALK, S_WAIT, S_DONE
  } state_e;

  state_e state_q;
  logic [10:0] len_q;
  logic        locked_q;
  logic [12:0] vcount_q;
  logic [papc_pkg::FreeBits-1:0] free_q;
  logic [1:0]  op_q;
  logic [VB-1:0] ver_q;
  logic [10:0] pos_q;
  logic [31:0] val_q;
  logic [10:0] lo_q, hi_q;
  logic [NB-1:0] slot_q;   // heap slot of version 0, stays below 2*LeafCount
  logic [NB-1:0] old_q, cur_q;
  logic [4:0]  depth_q;
  logic        rd_pend_q;
  logic [2:0]  status_q;
  logic [31:0] rv_q;
  logic [11:0] nv_q;
  logic        done_q;

  logic [10:0] n_eff;
  always_comb begin
    n_eff = len_q;
    if (len_q == 11'd0) n_eff = 11'd1;
    else if (len_q > 11'(papc_pkg::LeafCount)) n_eff = 11'(papc_pkg::LeafCount);
  end

  papc_pkg::node_wr_t wr;
  logic [NB-1:0] rd_addr;
  logic [NB-1:0] rd_left, rd_right;
  logic [31:0]   rd_val;
  logic          root_we;
  logic [NB-1:0] root_rd;

  papc_node_mem u_nodes (
    .clk_i, .wr_i(wr), .rd_addr_i(rd_addr),
    .rd_left_o(rd_left), .rd_right_o(rd_right), .rd_val_o(rd_val)
  );

  logic [NB-1:0] root_q;
  papc_root_mem u_roots (
    .clk_i, .we_i(root_we), .wr_addr_i(vcount_q[VB-1:0] + VB'(1)),
    .wr_data_i(op_q == papc_pkg::OpQuery ? root_rd : cur_q),
    .rd_addr_i(ver_q), .rd_data_o(root_q)
  );

  // root of the named version: version 0 is fixed at node 1
  assign root_rd = (ver_q == '0) ? NB'(1) : root_q;

  logic [10:0] mid;
  logic go_left;
  assign mid     = 11'((12'(lo_q) + 12'(hi_q)) >> 1);
  assign go_left = pos_q <= mid;

  // the node being walked: root from the table right after S_WAIT, else last read child
  logic [NB-1:0] walk_node;
  assign walk_node = rd_pend_q ? (go_left ? rd_left : rd_right) : old_q;

  always_comb begin
    wr = '0;
    root_we = 1'b0;
    rd_addr = walk_node;
    if (state_q == S_LOAD) begin
      wr.we = 1'b1;
      wr.addr = slot_q;
      if (lo_q != hi_q) begin
        wr.wr_left = 1'b1; wr.wr_right = 1'b1;
        wr.left = {slot_q[NB-2:0], 1'b0};
        wr.right = {slot_q[NB-2:0], 1'b1};
      end else begin
        wr.wr_val = 1'b1;
        wr.val = val_q;
      end
    end
    if (state_q == S_WALK && op_q == papc_pkg::OpModify && rd_pend_q) begin
      wr.we = 1'b1;
      wr.addr = cur_q;
      if (lo_q != hi_q) begin
        wr.wr_left = 1'b1; wr.wr_right = 1'b1;
        wr.left  = go_left ? cur_q + NB'(1) : rd_left;
        wr.right = go_left ? rd_right : cur_q + NB'(1);
      end else begin
        wr.wr_val = 1'b1;
        wr.val = val_q;
      end
    end
    if (state_q == S_ROOT) root_we = 1'b0;
    if (state_q == S_WAIT) root_we = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      len_q     <= 11'd1024;
      locked_q  <= 1'b0;
      vcount_q  <= '0;
      free_q    <= papc_pkg::FreeBits'(2 * papc_pkg::LeafCount);
      done_q    <= 1'b0;
      rd_pend_q <= 1'b0;
      op_q <= '0; ver_q <= '0; pos_q <= '0; val_q <= '0;
      lo_q <= '0; hi_q <= '0; slot_q <= '0; old_q <= '0; cur_q <= '0;
      depth_q <= '0;
      status_q <= '0; rv_q <= '0; nv_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (cfg_we_i && !locked_q) len_q <= cfg_wdata_i;
      unique case (state_q)
        S_IDLE: begin
          if (start_i) begin
            locked_q <= 1'b1;
            op_q <= op_i; ver_q <= version_i; pos_q <= position_i; val_q <= value_i;
            lo_q <= 11'd1; hi_q <= n_eff;
            slot_q <= NB'(1);
            rd_pend_q <= 1'b0;
            status_q <= papc_pkg::StOk; rv_q <= '0; nv_q <= '0;
            state_q <= S_DONE;
            if (op_i == papc_pkg::OpLoad) begin
              if (vcount_q != 13'd0) status_q <= papc_pkg::StLate;
              else if (position_i == 11'd0 || position_i > n_eff)
                status_q <= papc_pkg::StBadPos;
              else state_q <= S_LOAD;
            end else if (op_i == papc_pkg::OpModify || op_i == papc_pkg::OpQuery) begin
              if (13'(version_i) > vcount_q) status_q <= papc_pkg::StBadVer;
              else if (position_i == 11'd0 || position_i > n_eff)
                status_q <= papc_pkg::StBadPos;
              else if (vcount_q + 13'd1 >= 13'(papc_pkg::VersionCount))
                status_q <= papc_pkg::StFull;
              else if (op_i == papc_pkg::OpModify) begin
                depth_q <= '0;
                state_q <= S_DEPTH;
              end else state_q <= S_ROOT;
            end
          end
        end
        S_LOAD: begin
          // leaf slots stay well inside the store for any length up to LeafCount
          if (lo_q == hi_q) begin
            state_q <= S_DONE;
          end else begin
            if (go_left) begin
              hi_q <= mid; slot_q <= {slot_q[NB-2:0], 1'b0};
            end else begin
              lo_q <= mid + 11'd1; slot_q <= {slot_q[NB-2:0], 1'b1};
            end
          end
        end
        S_DEPTH: begin
          // count the path length one level a cycle, then reserve the nodes
          if (lo_q == hi_q) begin
            lo_q <= 11'd1; hi_q <= n_eff;
            if (18'(free_q) + 18'(depth_q) + 18'd1 > 18'(papc_pkg::NodeCount)) begin
              status_q <= papc_pkg::StFull;
              state_q  <= S_DONE;
            end else begin
              cur_q  <= NB'(free_q);
              free_q <= free_q + papc_pkg::FreeBits'(depth_q) + papc_pkg::FreeBits'(1);
              state_q <= S_ROOT;
            end
          end else begin
            depth_q <= depth_q + 5'd1;
            if (go_left) hi_q <= mid; else lo_q <= mid + 11'd1;
          end
        end
        S_ROOT: begin
          // root table read lands next cycle
          state_q <= S_WAIT;
        end
        S_WAIT: begin
          old_q <= root_rd;
          nv_q  <= 12'(vcount_q + 13'd1);
          vcount_q <= vcount_q + 13'd1;
          state_q <= S_WALK;
        end
        S_WALK: begin
          if (!rd_pend_q) begin
            rd_pend_q <= 1'b1;
          end else if (lo_q == hi_q) begin
            if (op_q == papc_pkg::OpQuery) rv_q <= rd_val;
            state_q <= S_DONE;
          end else begin
            old_q <= walk_node;
            rd_pend_q <= 1'b0;
            cur_q <= cur_q + NB'(1);
            if (go_left) hi_q <= mid; else lo_q <= mid + 11'd1;
          end
        end
        S_DONE: begin
          done_q  <= 1'b1;
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign busy_o        = state_q != S_IDLE;
  assign done_o        = done_q;
  assign status_o      = status_q;
  assign read_value_o  = rv_q;
  assign new_version_o = nv_q;
endmodule
